// ===== sv/aes128_pkg.sv =====
// Shared AES tables and byte-level round functions.
package aes128_pkg;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
		8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
		8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
		8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
		8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
		8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
		8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
		8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
		8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
		8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
		8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
		8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
		8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
		8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
		8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
		8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
	};

	localparam logic [7:0] SBOX_DEC [256] = '{
		8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
		8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
		8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
		8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
		8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
		8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
		8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
		8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
		8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
		8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
		8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
		8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
		8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
		8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
		8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
	};

	localparam logic [7:0] RCON_FIRST = 8'h01;
	localparam logic [7:0] GF_POLY    = 8'h1b;
	localparam int unsigned NUM_ROUNDS = 10;

	typedef logic [127:0] block_t;

	function automatic logic [7:0] xtime(input logic [7:0] v);
		xtime = {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
	endfunction

	// Byte n of the state sits at bits 127-8n downto 120-8n.
	function automatic block_t sub_shift(input block_t s, input logic inv);
		block_t o;
		int src;
		o = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				src = inv ? ((c - r + 4) & 3) : ((c + r) & 3);
				o[127 - 8 * (c * 4 + r) -: 8] = inv ? SBOX_DEC[s[127 - 8 * (src * 4 + r) -: 8]]
				                                    : SBOX[s[127 - 8 * (src * 4 + r) -: 8]];
			end
		end
		return o;
	endfunction

	function automatic block_t mix_cols(input block_t s, input logic inv);
		block_t o;
		logic [7:0] a [4];
		logic [7:0] m1 [4];
		logic [7:0] m2 [4];
		logic [7:0] m3 [4];
		logic [7:0] m9 [4];
		logic [7:0] m11 [4];
		logic [7:0] m13 [4];
		logic [7:0] m14 [4];
		logic [7:0] x4;
		logic [7:0] x8;
		o = '0;
		for (int c = 0; c < 4; c++) begin
			for (int i = 0; i < 4; i++) begin
				a[i]   = s[127 - 8 * (c * 4 + i) -: 8];
				m1[i]  = a[i];
				m2[i]  = xtime(a[i]);
				x4     = xtime(m2[i]);
				x8     = xtime(x4);
				m3[i]  = m2[i] ^ a[i];
				m9[i]  = x8 ^ a[i];
				m11[i] = x8 ^ m2[i] ^ a[i];
				m13[i] = x8 ^ x4 ^ a[i];
				m14[i] = x8 ^ x4 ^ m2[i];
			end
			for (int r = 0; r < 4; r++) begin
				if (inv)
					o[127 - 8 * (c * 4 + r) -: 8] = m14[r] ^ m11[(r + 1) & 3]
					                              ^ m13[(r + 2) & 3] ^ m9[(r + 3) & 3];
				else
					o[127 - 8 * (c * 4 + r) -: 8] = m2[r] ^ m3[(r + 1) & 3]
					                              ^ m1[(r + 2) & 3] ^ m1[(r + 3) & 3];
			end
		end
		return o;
	endfunction

endpackage

// ===== sv/aes128_round.sv =====
// One registered cipher round, encrypt or decrypt per transaction.
module aes128_round (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  logic            last,
	input  logic            v_in,
	input  logic            kind_in,
	input  aes128_pkg::block_t data_in,
	input  aes128_pkg::block_t key_enc,
	input  aes128_pkg::block_t key_dec,
	output logic            v_s1,
	output logic            kind_s1,
	output aes128_pkg::block_t data_s1
);
	import aes128_pkg::*;

	block_t enc_sh, enc_nx, dec_sh, dec_nx;

	always_comb begin
		enc_sh = sub_shift(data_in, 1'b0);
		enc_nx = (last ? enc_sh : mix_cols(enc_sh, 1'b0)) ^ key_enc;
		dec_sh = sub_shift(data_in, 1'b1) ^ key_dec;
		dec_nx = last ? dec_sh : mix_cols(dec_sh, 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (advance) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_s1 <= kind_in;
			data_s1 <= kind_in ? dec_nx : enc_nx;
		end
	end

endmodule

// ===== sv/aes128_block_cipher_unit.sv =====
// AES-128 cipher top level: key registers, round key expansion and round pipeline.
//
// Fully unrolled AES-128 engine taking one block per cycle. A transaction passes an
// initial key-add stage and ten registered round stages; the whole pipeline stalls
// together when the output is not taken. After reset and after every key register
// write the round keys are rebuilt by a sequencer that produces one round key per
// cycle; input is held off while it runs. Kind 0 encrypts, kind 1 decrypts.
module aes128_block_cipher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] result_high,
	output logic [63:0] result_low
);
	import aes128_pkg::*;

	localparam logic CFG_KEY_HIGH = 1'b0;
	localparam logic CFG_KEY_LOW  = 1'b1;
	localparam logic [3:0] LAST_ROUND = 4'(NUM_ROUNDS);

	logic [63:0] key_high_q, key_low_q;
	logic        kx_busy_q;
	logic [3:0]  kx_cnt_q;
	logic [7:0]  rc_q;
	block_t      kx_prev_q;
	block_t      kx_next;
	logic [31:0] kx_t;
	block_t      rk_q [1:10];
	block_t      rk [0:10];

	logic        advance;
	logic        v [0:10];
	logic        k [0:10];
	block_t      d [0:10];

	assign cfg_ready = 1'b1;
	assign advance   = !v[10] || out_ready;
	assign in_ready  = advance && !kx_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_KEY_HIGH: key_high_q <= cfg_data;
				CFG_KEY_LOW:  key_low_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Key schedule sequencer: step 0 loads the key, steps 1..10 build one round key each.
	always_comb begin
		kx_t = {SBOX[kx_prev_q[23:16]] ^ rc_q, SBOX[kx_prev_q[15:8]],
		        SBOX[kx_prev_q[7:0]], SBOX[kx_prev_q[31:24]]};
		kx_next[127:96] = kx_prev_q[127:96] ^ kx_t;
		kx_next[95:64]  = kx_prev_q[95:64] ^ kx_next[127:96];
		kx_next[63:32]  = kx_prev_q[63:32] ^ kx_next[95:64];
		kx_next[31:0]   = kx_prev_q[31:0] ^ kx_next[63:32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kx_busy_q <= 1'b1;
			kx_cnt_q  <= '0;
		end else if (cfg_valid) begin
			kx_busy_q <= 1'b1;
			kx_cnt_q  <= '0;
		end else if (kx_busy_q) begin
			kx_busy_q <= (kx_cnt_q != LAST_ROUND);
			kx_cnt_q  <= kx_cnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (kx_busy_q && !cfg_valid) begin
			if (kx_cnt_q == '0) begin
				kx_prev_q <= {key_high_q, key_low_q};
				rc_q      <= RCON_FIRST;
			end else begin
				kx_prev_q        <= kx_next;
				rc_q             <= xtime(rc_q);
				rk_q[kx_cnt_q] <= kx_next;
			end
		end
	end

	always_comb begin
		rk[0] = {key_high_q, key_low_q};
		for (int i = 1; i <= 10; i++)
			rk[i] = rk_q[i];
	end

	// Initial whitening stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v[0] <= 1'b0;
		end else if (advance) begin
			v[0] <= in_valid && in_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			k[0] <= kind;
			d[0] <= {block_high, block_low} ^ (kind ? rk[10] : rk[0]);
		end
	end

	for (genvar r = 1; r <= 10; r++) begin : g_round
		aes128_round u_round (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.last    (r == 10),
			.v_in    (v[r-1]),
			.kind_in (k[r-1]),
			.data_in (d[r-1]),
			.key_enc (rk[r]),
			.key_dec (rk[10-r]),
			.v_s1    (v[r]),
			.kind_s1 (k[r]),
			.data_s1 (d[r])
		);
	end

	assign out_valid   = v[10];
	assign result_high = d[10][127:64];
	assign result_low  = d[10][63:0];

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !kx_busy_q)
		else $error("input accepted during key expansion");

	a_cfg_starts_kx: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |=> kx_busy_q && kx_cnt_q == '0)
		else $error("key write did not restart expansion");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		kx_busy_q |-> kx_cnt_q <= LAST_ROUND)
		else $error("key expansion counter out of range");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> v[5] == $past(v[5]) && v[0] == $past(v[0]))
		else $error("pipeline moved during stall");

endmodule

// ===== tb/tb_aes128_block_cipher_unit.sv =====
// Self-checking testbench for the AES-128 cipher unit: predicts each block and checks it in order.
module tb_aes128_block_cipher_unit;
	import aes128_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam logic KIND_ENC = 1'b0;
	localparam logic KIND_DEC = 1'b1;
	localparam logic REG_KEY_HIGH = 1'b0;
	localparam logic REG_KEY_LOW = 1'b1;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready, cfg_index;
	logic [63:0] cfg_data;
	logic in_valid, in_ready, kind;
	logic [63:0] block_high, block_low;
	logic out_valid, out_ready;
	logic [63:0] result_high, result_low;

	int send_idle_pct, recv_stall_pct;
	int stall_cycles;

	aes128_block_cipher_unit dut (.*);

	// Golden cipher with its own key copy.
	class cipher_scoreboard;
		logic [63:0] key_hi, key_lo;
		logic [127:0] pending_blocks [$];
		int fail_count;

		function void set_key(logic idx, logic [63:0] val);
			if (idx == REG_KEY_HIGH) key_hi = val;
			else key_lo = val;
		endfunction

		function logic [7:0] gmul(logic [7:0] x, logic [7:0] y);
			logic [7:0] acc;
			acc = 0;
			for (int n = 0; n < 8; n++) begin
				if (y[n]) acc ^= x;
				x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
			end
			return acc;
		endfunction

		function logic [127:0] cipher(logic dec, logic [127:0] blk);
			logic [7:0] rk [176];
			logic [7:0] s [16];
			logic [7:0] o [16];
			logic [7:0] t [4];
			logic [7:0] a [4];
			logic [7:0] rc, tmp;
			logic [127:0] key, res;
			logic [7:0] cf [4];
			int rnd, src;
			key = {key_hi, key_lo};
			for (int n = 0; n < 16; n++) begin
				rk[n] = key[127 - 8 * n -: 8];
				s[n] = blk[127 - 8 * n -: 8];
			end
			rc = 8'h01;
			for (int w = 4; w < 44; w++) begin
				for (int n = 0; n < 4; n++) t[n] = rk[(w - 1) * 4 + n];
				if (w % 4 == 0) begin
					tmp = t[0];
					t[0] = SBOX[t[1]] ^ rc;
					t[1] = SBOX[t[2]];
					t[2] = SBOX[t[3]];
					t[3] = SBOX[tmp];
					rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
				end
				for (int n = 0; n < 4; n++) rk[w * 4 + n] = rk[(w - 4) * 4 + n] ^ t[n];
			end
			if (dec) cf = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
			else cf = '{8'h02, 8'h03, 8'h01, 8'h01};
			for (int n = 0; n < 16; n++) s[n] ^= rk[(dec ? 160 : 0) + n];
			for (int i = 1; i <= 10; i++) begin
				rnd = dec ? 10 - i : i;
				for (int c = 0; c < 4; c++)
					for (int r = 0; r < 4; r++) begin
						src = dec ? ((c - r + 4) % 4) : ((c + r) % 4);
						o[c * 4 + r] = dec ? SBOX_DEC[s[src * 4 + r]] : SBOX[s[src * 4 + r]];
					end
				s = o;
				// encrypt mixes before the key add, decrypt after; last round skips mixing
				if (dec) for (int n = 0; n < 16; n++) s[n] ^= rk[rnd * 16 + n];
				if (i < 10)
					for (int c = 0; c < 4; c++) begin
						for (int r = 0; r < 4; r++) a[r] = s[c * 4 + r];
						for (int r = 0; r < 4; r++)
							s[c * 4 + r] = gmul(a[0], cf[(4 - r) % 4]) ^ gmul(a[1], cf[(5 - r) % 4])
							             ^ gmul(a[2], cf[(6 - r) % 4]) ^ gmul(a[3], cf[(7 - r) % 4]);
					end
				if (!dec) for (int n = 0; n < 16; n++) s[n] ^= rk[rnd * 16 + n];
			end
			for (int n = 0; n < 16; n++) res[127 - 8 * n -: 8] = s[n];
			return res;
		endfunction

		function void note_block(logic k, logic [63:0] hi, logic [63:0] lo);
			pending_blocks.push_back(cipher(k, {hi, lo}));
		endfunction

		function void check_result(logic [63:0] hi, logic [63:0] lo);
			logic [127:0] exp_blk;
			if (pending_blocks.size() == 0) begin
				$error("unexpected result %h_%h", hi, lo);
				fail_count++;
				return;
			end
			exp_blk = pending_blocks.pop_front();
			if (hi !== exp_blk[127:64]) begin
				$error("result_high expected %h actual %h", exp_blk[127:64], hi);
				fail_count++;
			end
			if (lo !== exp_blk[63:0]) begin
				$error("result_low expected %h actual %h", exp_blk[63:0], lo);
				fail_count++;
			end
		endfunction
	endclass

	cipher_scoreboard sb;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Monitor, watchdog and receiver stalls.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) sb.check_result(result_high, result_low);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_aes128_block_cipher_unit NOT OK");
			$finish;
		end
	end

	// Valid stays up across back-to-back sends; it drops only when the sender idles.
	task automatic send_block(logic k, logic [63:0] hi, logic [63:0] lo);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		kind <= k;
		block_high <= hi;
		block_low <= lo;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_block(k, hi, lo);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		while (sb.pending_blocks.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_key(logic idx, logic [63:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_key(idx, val);
		@(negedge clk);
		cfg_valid <= 0;
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic random_phase(int count, int idle_pct, int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(7))
				0: send_block(1'($urandom_range(1)), '0, rand64());
				1: send_block(1'($urandom_range(1)), rand64(), '1);
				default: send_block(1'($urandom_range(1)), rand64(), rand64());
			endcase
		end
	endtask

	initial begin
		logic [127:0] ct;
		sb = new();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		stall_cycles = 0;
		arst_n = 0;
		cfg_valid = 0; cfg_index = 0; cfg_data = 0;
		in_valid = 0; kind = 0; block_high = 0; block_low = 0;
		out_ready = 1;
		repeat (3) @(negedge clk);
		arst_n = 1;

		// Directed: reset key, extremes, FIPS-197 vector and its inverse.
		send_block(KIND_ENC, '0, '0);
		send_block(KIND_DEC, '0, '0);
		send_block(KIND_ENC, '1, '1);
		send_block(KIND_DEC, '1, '1);
		wait_drained();
		write_key(REG_KEY_HIGH, 64'h0001020304050607);
		write_key(REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
		send_block(KIND_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
		send_block(KIND_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
		ct = sb.cipher(KIND_ENC, {64'h0123456789abcdef, 64'hfedcba9876543210});
		send_block(KIND_DEC, ct[127:64], ct[63:0]);
		send_block(KIND_ENC, 64'h8000000000000000, 64'h0000000000000001);
		wait_drained();
		write_key(REG_KEY_HIGH, '1);
		write_key(REG_KEY_LOW, '1);
		send_block(KIND_ENC, '0, '1);
		send_block(KIND_DEC, '1, '0);
		wait_drained();

		random_phase(500, 0, 0);
		wait_drained();
		write_key(REG_KEY_HIGH, rand64());
		write_key(REG_KEY_LOW, rand64());
		random_phase(500, 64, 0);
		wait_drained();
		write_key(REG_KEY_LOW, '0);
		random_phase(500, 0, 64);
		wait_drained();
		write_key(REG_KEY_HIGH, '0);
		write_key(REG_KEY_LOW, rand64());
		random_phase(500, 29, 29);
		wait_drained();

		if (sb.fail_count == 0)
			$display("tb_aes128_block_cipher_unit OK");
		else
			$display("tb_aes128_block_cipher_unit NOT OK");
		$finish;
	end
endmodule
